// ----- design/tdab_pkg.sv -----
// Shared types, constants and helpers of the table driven automata bank.
package tdab_pkg;

  // Bank dimensions
  localparam int PLANTS          = 8;
  localparam int TRANS_PER_PLANT = 16;
  localparam int NUM_STATES      = 16;
  localparam int EVENT_BITS      = 8;

  // Fixed field widths of the transfer payloads
  localparam int CMD_W    = 2;
  localparam int PLANT_W  = 3;
  localparam int STATE_W  = 4;
  localparam int EVENT_W  = 8;
  localparam int STATUS_W = 2;
  localparam int ACT_W    = 4;

  // Derived widths
  localparam int PIDX_W      = $clog2(PLANTS);
  localparam int TIDX_W      = $clog2(TRANS_PER_PLANT);
  localparam int CNT_W       = $clog2(TRANS_PER_PLANT + 1);
  localparam int TABLE_DEPTH = PLANTS * TRANS_PER_PLANT;
  localparam int TBL_AW      = PIDX_W + TIDX_W;

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_ACTIVE_PLANTS = REG_IDX_W'(0);
  localparam logic [ACT_W-1:0]     ACTIVE_RESET      = ACT_W'(8);

  localparam logic [EVENT_W-1:0] EVENT_MASK = EVENT_W'((1 << EVENT_BITS) - 1);

  typedef enum logic [CMD_W-1:0] {
    OP_ADD   = 2'd0,
    OP_SET   = 2'd1,
    OP_BCAST = 2'd2,
    OP_NOP   = 2'd3
  } tdab_op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_PLANT = 2'd2
  } tdab_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_EXEC,
    S_SCAN,
    S_EMIT
  } tdab_state_e;

  // One stored transition
  typedef struct packed {
    logic [STATE_W-1:0] src;
    logic [EVENT_W-1:0] ev;
    logic [STATE_W-1:0] dst;
  } tdab_entry_t;

  // Input item as held by the datapath
  typedef struct packed {
    tdab_op_e           op;
    logic [PLANT_W-1:0] plant;
    logic [STATE_W-1:0] from_st;
    logic [STATE_W-1:0] to_st;
    logic [EVENT_W-1:0] ev;
  } tdab_item_t;

  // One result item
  typedef struct packed {
    logic [PLANT_W-1:0]  plant_id;
    logic                fired;
    logic [STATE_W-1:0]  old_state;
    logic [STATE_W-1:0]  new_state;
    logic [STATUS_W-1:0] status;
    logic                last;
  } tdab_res_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;  // capture the input item
    logic exec;  // perform add/set and push its result
    logic scan;  // one step of the table walk
    logic emit;  // push a broadcast result, advance to next plant
  } tdab_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    tdab_op_e op;
    logic     n_zero;
    logic     scan_done;
    logic     last_plant;
    logic     out_free;
  } tdab_sts_t;

  // Clamp a state number into the legal range
  function automatic logic [STATE_W-1:0] sat_state(logic [STATE_W-1:0] s);
    if (int'(s) >= NUM_STATES) begin
      return STATE_W'(NUM_STATES - 1);
    end
    return s;
  endfunction

endpackage

// ----- design/tdab_if.sv -----
// Valid/ready channel interfaces for commands in and results out.
interface tdab_in_if;
  logic                         valid;
  logic                         ready;
  logic [tdab_pkg::CMD_W-1:0]   cmd;
  logic [tdab_pkg::PLANT_W-1:0] plant_index;
  logic [tdab_pkg::STATE_W-1:0] from_state;
  logic [tdab_pkg::STATE_W-1:0] to_state;
  logic [tdab_pkg::EVENT_W-1:0] event_code;

  modport source (output valid, cmd, plant_index, from_state, to_state, event_code,
                  input ready);
  modport sink (input valid, cmd, plant_index, from_state, to_state, event_code,
                output ready);
endinterface

interface tdab_out_if;
  logic                          valid;
  logic                          ready;
  logic [tdab_pkg::PLANT_W-1:0]  plant_id;
  logic                          fired;
  logic [tdab_pkg::STATE_W-1:0]  old_state;
  logic [tdab_pkg::STATE_W-1:0]  new_state;
  logic [tdab_pkg::STATUS_W-1:0] status;
  logic                          last;

  modport source (output valid, plant_id, fired, old_state, new_state, status, last,
                  input ready);
  modport sink (input valid, plant_id, fired, old_state, new_state, status, last,
                output ready);
endinterface

// ----- design/table_driven_automata_bank.sv -----
// Top level of the table driven automata bank: channels, config register, controller, datapath.
//
// Bank of 8 programmable automata with 16 transitions each. An add or set command
// passes through the dispatch and exec states and writes its result into the output
// register in exec, which waits while a result is still pending there. A broadcast
// walks every active plant in order, reading the single-port transition table one
// entry per cycle and stopping at the first match; each plant's result is posted
// from the emit state, which waits while the output register is occupied. The next
// command is taken once the current one finishes; a finished result may still be
// waiting in the output register. The table holds no clear; register active_plants
// (address 0, reset 8) sets how many plants, from plant 0, see a broadcast. The user
// must write it only while the block is idle; the block itself does not enforce this.
module table_driven_automata_bank (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  tdab_in_if.sink                         in_ch,
  tdab_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tdab_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tdab_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tdab_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import tdab_pkg::*;

  logic [ACT_W-1:0]     active_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;
  tdab_cmd_t            ctl;
  tdab_sts_t            sts;
  tdab_item_t           item;
  tdab_res_t            res;

  // Config register access
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && reg_idx == REG_ACTIVE_PLANTS;
  assign prdata  = (reg_idx == REG_ACTIVE_PLANTS) ? APB_DATA_W'(active_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ACTIVE_RESET;
    end else if (cfg_wr) begin
      active_q <= pwdata[ACT_W-1:0];
    end
  end

  // Input payload
  assign item = '{op: tdab_op_e'(in_ch.cmd), plant: in_ch.plant_index,
                  from_st: in_ch.from_state, to_st: in_ch.to_state,
                  ev: in_ch.event_code};

  tdab_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  tdab_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .sts_o           (sts),
    .item_i          (item),
    .active_plants_i (active_q),
    .out_valid_o     (out_ch.valid),
    .out_ready_i     (out_ch.ready),
    .res_o           (res)
  );

  // Result payload
  assign out_ch.plant_id  = res.plant_id;
  assign out_ch.fired     = res.fired;
  assign out_ch.old_state = res.old_state;
  assign out_ch.new_state = res.new_state;
  assign out_ch.status    = res.status;
  assign out_ch.last      = res.last;

endmodule

// ----- design/tdab_ctrl.sv -----
// Controller state machine sequencing add, set and broadcast commands.
module tdab_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tdab_pkg::tdab_sts_t sts_i,
  output tdab_pkg::tdab_cmd_t ctl_o
);
  import tdab_pkg::*;

  tdab_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (sts_i.op)
          OP_ADD, OP_SET: state_d = S_EXEC;
          OP_BCAST:       state_d = sts_i.n_zero ? S_IDLE : S_SCAN;
          OP_NOP:         state_d = S_IDLE;
          default:        state_d = S_IDLE;
        endcase
      end
      S_EXEC: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      S_SCAN: begin
        if (sts_i.scan_done) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) state_d = sts_i.last_plant ? S_IDLE : S_SCAN;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o = 1'b0;
    ctl_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        ctl_o.load = in_valid_i;
      end
      S_DISPATCH: ;
      S_EXEC:     ctl_o.exec = sts_i.out_free;
      S_SCAN:     ctl_o.scan = 1'b1;
      S_EMIT:     ctl_o.emit = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

// ----- design/tdab_datapath.sv -----
// Datapath: plant registers, transition table memory, walk counters, result register.
module tdab_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tdab_pkg::tdab_cmd_t        ctl_i,
  output tdab_pkg::tdab_sts_t        sts_o,
  input  tdab_pkg::tdab_item_t       item_i,
  input  logic [tdab_pkg::ACT_W-1:0] active_plants_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output tdab_pkg::tdab_res_t        res_o
);
  import tdab_pkg::*;

  tdab_entry_t        mem [TABLE_DEPTH];
  tdab_entry_t        rdata_q;
  tdab_item_t         item_q;
  logic [STATE_W-1:0] state_q [PLANTS];
  logic [CNT_W-1:0]   count_q [PLANTS];
  logic [PIDX_W-1:0]  pidx_q;
  logic [CNT_W-1:0]   t_q;
  logic               rd_vld_q;
  logic               hit_q;
  logic [STATE_W-1:0] dst_q;
  logic               out_valid_q;
  tdab_res_t          res_q, res_d;

  logic [PIDX_W-1:0]  pa;
  logic               bad_plant, full, add_ok, set_ok;
  logic [ACT_W-1:0]   n_act;
  logic [CNT_W-1:0]   cnt_cur;
  logic [STATE_W-1:0] cur_st;
  logic               more, match_now, last_plant, out_free, push;
  tdab_entry_t        wentry;

  // Item decode for add/set
  assign pa        = item_q.plant[PIDX_W-1:0];
  assign bad_plant = int'(item_q.plant) >= PLANTS;
  assign full      = int'(count_q[pa]) >= TRANS_PER_PLANT;
  assign add_ok    = ctl_i.exec && item_q.op == OP_ADD && !bad_plant && !full;
  assign set_ok    = ctl_i.exec && item_q.op == OP_SET && !bad_plant;
  assign wentry    = '{src: item_q.from_st, ev: item_q.ev, dst: item_q.to_st};

  // Broadcast walk
  assign n_act      = (int'(active_plants_i) > PLANTS) ? ACT_W'(PLANTS) : active_plants_i;
  assign cnt_cur    = count_q[pidx_q];
  assign cur_st     = state_q[pidx_q];
  assign more       = t_q < cnt_cur;
  assign match_now  = rd_vld_q && rdata_q.src == cur_st && rdata_q.ev == item_q.ev;
  assign last_plant = (ACT_W'(pidx_q) + ACT_W'(1)) == n_act;

  assign out_free = !out_valid_q || out_ready_i;
  assign push     = ctl_i.exec || ctl_i.emit;

  assign sts_o = '{op:         item_q.op,
                   n_zero:     n_act == '0,
                   scan_done:  match_now || (!rd_vld_q && !more),
                   last_plant: last_plant,
                   out_free:   out_free};

  // Result to be pushed
  always_comb begin
    res_d = '{plant_id: item_q.plant, fired: 1'b0, old_state: state_q[pa],
              new_state: state_q[pa], status: ST_OK, last: 1'b1};
    if (ctl_i.emit) begin
      res_d = '{plant_id: PLANT_W'(pidx_q), fired: hit_q, old_state: cur_st,
                new_state: hit_q ? dst_q : cur_st, status: ST_OK, last: last_plant};
    end else if (bad_plant) begin
      res_d.old_state = '0;
      res_d.new_state = '0;
      res_d.status    = ST_BAD_PLANT;
    end else if (item_q.op == OP_ADD && full) begin
      res_d.status = ST_FULL;
    end else if (item_q.op == OP_SET) begin
      res_d.new_state = item_q.to_st;
    end
  end

  // Transition table: one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (add_ok) begin
      mem[{pa, count_q[pa][TIDX_W-1:0]}] <= wentry;
    end
    if (ctl_i.scan && more) begin
      rdata_q <= mem[{pidx_q, t_q[TIDX_W-1:0]}];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      item_q <= '{op: tdab_op_e'(item_i.op), plant: item_i.plant,
                  from_st: sat_state(item_i.from_st), to_st: sat_state(item_i.to_st),
                  ev: item_i.ev & EVENT_MASK};
    end
    if (ctl_i.scan && match_now) begin
      dst_q <= rdata_q.dst;
    end
    if (push) begin
      res_q <= res_d;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PLANTS; i++) begin
        state_q[i] <= '0;
        count_q[i] <= '0;
      end
      pidx_q      <= '0;
      t_q         <= '0;
      rd_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (ctl_i.load || ctl_i.emit) begin
        pidx_q   <= ctl_i.load ? '0 : pidx_q + PIDX_W'(1);
        t_q      <= '0;
        rd_vld_q <= 1'b0;
        hit_q    <= 1'b0;
      end else if (ctl_i.scan) begin
        rd_vld_q <= more;
        if (more) t_q <= t_q + CNT_W'(1);
        if (match_now) hit_q <= 1'b1;
      end
      if (ctl_i.emit && hit_q) begin
        state_q[pidx_q] <= dst_q;
      end
      if (set_ok) begin
        state_q[pa] <= item_q.to_st;
      end
      if (add_ok) begin
        count_q[pa] <= count_q[pa] + CNT_W'(1);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  // A pending result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> out_free)
    else $error("result pushed over a pending transfer");

  // Table fill never passes its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   int'(cnt_cur) <= TRANS_PER_PLANT)
    else $error("transition count above table depth");

  // During the walk, read data is only flagged valid after a step issued a read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   ctl_i.scan && rd_vld_q |-> $past(ctl_i.scan && more))
    else $error("table read data flagged without a read");

  // A fired result always moves to the stored destination
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   ctl_i.emit && hit_q |=> res_q.fired && res_q.new_state == $past(dst_q))
    else $error("fired result lost its destination state");

endmodule
